// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define CDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define CDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cdf_pkg.sv
package cdf_pkg;

    localparam logic [7:0]  START_BYTE      = 8'h01;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] MAX_LENGTH_INIT = 16'd1024;

    // result kind codes
    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_GOOD     = 3'd1;
    localparam logic [2:0] KIND_CHK_ERR  = 3'd2;
    localparam logic [2:0] KIND_TOO_LONG = 3'd3;
    localparam logic [2:0] KIND_CRC_ERR  = 3'd4;

    // one byte word sitting in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_word_t;

    // one result word from the frame logic
    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [7:0]  ptype;
        logic [15:0] plen;
    } result_word_t;

    // crc-16/xmodem, one byte, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/cdf_in_stage.sv
module cdf_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               take,
    output cdf_pkg::byte_word_t word
);
    import cdf_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // room when empty or when the held word moves on this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            data_reg <= rx_byte;
        end
    end

    assign word.valid = valid_reg;
    assign word.data  = data_reg;

endmodule

// File: rtl/cdf_frame_fsm.sv
module cdf_frame_fsm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           byte_in,
    input  logic [15:0]          max_length,
    output cdf_pkg::result_word_t res
);
    import cdf_pkg::*;

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_TYPE    = 8'b0000_0010,
        PH_LEN_HI  = 8'b0000_0100,
        PH_LEN_LO  = 8'b0000_1000,
        PH_CHK     = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CRC1    = 8'b0100_0000,
        PH_CRC2    = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] crc_upd;
    logic [7:0]  hdr_sum;

    assign crc_upd = crc_feed(crc_reg, byte_in);
    assign hdr_sum = type_reg + len_reg[15:8] + len_reg[7:0];

    // one byte step of the frame parser
    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        crc_next    = crc_reg;
        res.valid   = 1'b0;
        res.kind    = KIND_DATA;
        res.data    = 8'h00;
        res.ptype   = type_reg;
        res.plen    = len_reg;
        case (phase_reg)
            PH_HUNT: begin
                if (byte_in == START_BYTE) begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_next  = byte_in;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_next   = {byte_in, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_next   = {len_reg[15:8], byte_in};
                phase_next = PH_CHK;
            end
            PH_CHK: begin
                if (byte_in != hdr_sum) begin
                    phase_next = PH_HUNT;
                    res.valid  = 1'b1;
                    res.kind   = KIND_CHK_ERR;
                end
                else if (len_reg > max_length) begin
                    phase_next = PH_HUNT;
                    res.valid  = 1'b1;
                    res.kind   = KIND_TOO_LONG;
                end
                else begin
                    crc_next    = 16'h0000;
                    remain_next = len_reg;
                    phase_next  = (len_reg == 16'h0000) ? PH_CRC1 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                crc_next    = crc_upd;
                remain_next = remain_reg - 16'd1;
                if (remain_next == 16'h0000) begin
                    phase_next = PH_CRC1;
                end
                res.valid = 1'b1;
                res.kind  = KIND_DATA;
                res.data  = byte_in;
            end
            PH_CRC1: begin
                crc_next   = crc_upd;
                phase_next = PH_CRC2;
            end
            PH_CRC2: begin
                crc_next   = crc_upd;
                phase_next = PH_HUNT;
                res.valid  = 1'b1;
                res.kind   = (crc_upd == 16'h0000) ? KIND_GOOD : KIND_CRC_ERR;
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // state update only when a word is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_HUNT;
            type_reg   <= 8'h00;
            len_reg    <= 16'h0000;
            remain_reg <= 16'h0000;
            crc_reg    <= 16'h0000;
        end
        else if (take) begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

// File: rtl/cdf_out_stage.sv
module cdf_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  cdf_pkg::result_word_t res,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            result_kind,
    output logic [7:0]            data_byte,
    output logic [7:0]            packet_type,
    output logic [15:0]           payload_length
);
    import cdf_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [2:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [7:0]  ptype_reg;
    logic [15:0] plen_reg;
    logic        load;

    // register can take a new word when empty or drained this cycle
    assign free = !valid_reg || out_ready;
    assign load = take && res.valid;

    always_comb
    begin
        valid_next = valid_reg;
        if (free) begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg  <= res.kind;
            data_reg  <= res.data;
            ptype_reg <= res.ptype;
            plen_reg  <= res.plen;
        end
    end

    assign out_valid      = valid_reg;
    assign result_kind    = kind_reg;
    assign data_byte      = data_reg;
    assign packet_type    = ptype_reg;
    assign payload_length = plen_reg;

endmodule

// File: rtl/crc16_packet_deframer_core.sv
// channel   | handshake              | payload
// ----------+------------------------+--------------------------------------------------
// input     | in_valid / in_ready    | rx_byte
// output    | out_valid / out_ready  | result_kind, data_byte, packet_type, payload_length
// config    | cfg_we (no wait)       | cfg_wdata -> max_length
//
// one byte word accepted per cycle unless the output stalls; the parser step and crc
// update sit between the input register and the result register, so a result word is
// registered from the byte word held in the input register as that word moves on
// reset (rst_n low, async) empties both registers, hunts for start, limit back to 1024
// a stalled output holds its word and stops the parser, byte words with no result too;
// the input register takes one more word, then in_ready drops until the output drains
module crc16_packet_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  packet_type,
    output logic [15:0] payload_length
);
    import cdf_pkg::*;

    logic [15:0]  max_length_reg;
    byte_word_t   in_word;
    result_word_t res;
    logic         out_free;
    logic         take;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_length_reg <= MAX_LENGTH_INIT;
        end
        else if (cfg_we) begin
            max_length_reg <= cfg_wdata;
        end
    end

    // held word moves on whenever the result register has room
    assign take = in_word.valid && out_free;

    cdf_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .word     (in_word)
    );

    cdf_frame_fsm u_frame_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .byte_in    (in_word.data),
        .max_length (max_length_reg),
        .res        (res)
    );

    cdf_out_stage u_out_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .res            (res),
        .free           (out_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .data_byte      (data_byte),
        .packet_type    (packet_type),
        .payload_length (payload_length)
    );

endmodule

// File: rtl/cdf_checker.sv
`include "assert_macros.svh"

module cdf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  result_kind,
    input logic [7:0]  data_byte,
    input logic [7:0]  packet_type,
    input logic [15:0] payload_length
);
    import cdf_pkg::*;

    logic [34:0] out_word;
    logic        out_stall;
    logic        status_word;
    logic        data_word;

    // output word views used below
    assign out_word    = {result_kind, data_byte, packet_type, payload_length};
    assign out_stall   = out_valid && !out_ready;
    assign status_word = out_valid && (result_kind != KIND_DATA);
    assign data_word   = out_valid && (result_kind == KIND_DATA);

    // stalled output word holds
    `CDF_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word changed")

    // kind stays within the defined codes
    `CDF_ASSERT_NOW(a_kind_range, out_valid, result_kind <= KIND_CRC_ERR, "undefined result kind")

    // only payload words carry a data byte
    `CDF_ASSERT_NOW(a_data_zero, status_word, data_byte == 8'h00, "data byte on a status word")

    // payload bytes only come from a frame with nonzero length
    `CDF_ASSERT_NOW(a_data_len, data_word, payload_length != 16'h0000, "payload byte, zero length")

    // a free output side always lets the input side move
    `CDF_ASSERT_NOW(a_no_deadlock, !out_valid && !in_ready, 1'b0, "input stalled, output empty")

endmodule

bind crc16_packet_deframer_core cdf_checker u_cdf_checker (.*);
